>>> sv/dfpa_pkg.sv
// Shared types, constants and microcode table for the distance frame parser averager.
package dfpa_pkg;

    localparam int BYTE_W    = 8;
    localparam int MEAN_W    = 16;
    localparam int STEP_W    = 3;
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = 4;

    localparam logic [BYTE_W-1:0] HDR_RESET = 8'hFF;

    typedef logic [1:0] phase_t;
    localparam phase_t PH_HUNT = 2'd0;
    localparam phase_t PH_HIGH = 2'd1;
    localparam phase_t PH_LOW  = 2'd2;
    localparam phase_t PH_CSUM = 2'd3;

    typedef logic [2:0] uop_t;
    localparam uop_t U_WAIT    = 3'd0;
    localparam uop_t U_PARSE   = 3'd1;
    localparam uop_t U_CLR     = 3'd2;
    localparam uop_t U_ACC     = 3'd3;
    localparam uop_t U_DIVINIT = 3'd4;
    localparam uop_t U_DIV     = 3'd5;
    localparam uop_t U_EMIT    = 3'd6;
    localparam uop_t U_NOP     = 3'd7;

    typedef logic [2:0] cond_t;
    localparam cond_t C_NEVER     = 3'd0;
    localparam cond_t C_ALWAYS    = 3'd1;
    localparam cond_t C_NO_IN     = 3'd2;
    localparam cond_t C_NO_RESULT = 3'd3;
    localparam cond_t C_ACC_MORE  = 3'd4;
    localparam cond_t C_DIV_MORE  = 3'd5;
    localparam cond_t C_OUT_BUSY  = 3'd6;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic in_take;
        logic has_result;
        logic acc_more;
        logic div_more;
        logic out_busy;
    } dp_status_t;

    function automatic ctrl_word_t ucode_rom(input step_t step);
        ctrl_word_t w;
        unique case (step)
            3'd0:    w = '{uop: U_WAIT,    cond: C_NO_IN,     target: 3'd0};
            3'd1:    w = '{uop: U_PARSE,   cond: C_NO_RESULT, target: 3'd0};
            3'd2:    w = '{uop: U_CLR,     cond: C_NEVER,     target: 3'd0};
            3'd3:    w = '{uop: U_ACC,     cond: C_ACC_MORE,  target: 3'd3};
            3'd4:    w = '{uop: U_DIVINIT, cond: C_NEVER,     target: 3'd0};
            3'd5:    w = '{uop: U_DIV,     cond: C_DIV_MORE,  target: 3'd5};
            3'd6:    w = '{uop: U_EMIT,    cond: C_OUT_BUSY,  target: 3'd6};
            default: w = '{uop: U_NOP,     cond: C_ALWAYS,    target: 3'd0};
        endcase
        return w;
    endfunction

endpackage

>>> sv/dfpa_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module dfpa_seq
    import dfpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t status,
    output uop_t       uop
);

    step_t      step_reg;
    step_t      step_next;
    ctrl_word_t word;
    logic       jump;

    assign word = ucode_rom(step_reg);
    assign uop  = word.uop;

    always_comb
    begin
        unique case (word.cond)
            C_NEVER:     jump = 1'b0;
            C_ALWAYS:    jump = 1'b1;
            C_NO_IN:     jump = !status.in_take;
            C_NO_RESULT: jump = !status.has_result;
            C_ACC_MORE:  jump = status.acc_more;
            C_DIV_MORE:  jump = status.div_more;
            C_OUT_BUSY:  jump = status.out_busy;
            default:     jump = 1'b0;
        endcase
        step_next = jump ? word.target : step_t'(step_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

>>> sv/dfpa_dp.sv
// Datapath: frame parser, reading ring, accumulator, serial divider and output register.
module dfpa_dp
    import dfpa_pkg::*;
#(
    parameter int DEPTH = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  uop_t              uop,
    output dp_status_t        status,
    input  logic              cfg_we,
    input  logic [BYTE_W-1:0] cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              operation,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [MEAN_W-1:0] mean_distance,
    output logic              valid_res,
    output logic              fresh
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = MEAN_W + CNT_W;

    logic [MEAN_W-1:0] ring [DEPTH];

    logic [BYTE_W-1:0] header_reg, header_next;
    logic              op_reg,    op_next;
    logic [BYTE_W-1:0] byte_reg,  byte_next;
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] hi_reg,    hi_next;
    logic [BYTE_W-1:0] lo_reg,    lo_next;
    logic [SLOT_W-1:0] slot_reg,  slot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg,   idx_next;
    logic [SUM_W-1:0]  acc_reg,   acc_next;
    logic [CNT_W-1:0]  rem_reg,   rem_next;
    logic [MEAN_W-1:0] dq_reg,    dq_next;
    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;
    logic              ovalid_reg, ovalid_next;
    logic [MEAN_W-1:0] mean_reg,  mean_next;
    logic              vres_reg,  vres_next;
    logic              fresh_reg, fresh_next;

    logic              in_take;
    logic              sum_ok;
    logic              frame_ok;
    logic              ring_we;
    logic              out_busy;
    logic [CNT_W:0]    idx_inc;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    trial_diff;
    logic              ge;

    assign in_stall  = (uop != U_WAIT);
    assign in_take   = in_valid && !in_stall;
    assign sum_ok    = BYTE_W'(header_reg + hi_reg + lo_reg) == byte_reg;
    assign frame_ok  = !op_reg && (phase_reg == PH_CSUM) && sum_ok;
    assign ring_we   = (uop == U_PARSE) && frame_ok;
    assign out_busy  = ovalid_reg && out_stall;
    assign idx_inc   = {1'b0, idx_reg} + 1'b1;
    assign trial     = {rem_reg, dq_reg[MEAN_W-1]};
    assign ge        = trial >= {1'b0, count_reg};
    assign trial_diff = trial - {1'b0, count_reg};

    assign status.in_take    = in_take;
    assign status.has_result = op_reg || frame_ok;
    assign status.acc_more   = idx_inc < {1'b0, count_reg};
    assign status.div_more   = (dcnt_reg != '0);
    assign status.out_busy   = out_busy;

    assign out_valid     = ovalid_reg;
    assign mean_distance = mean_reg;
    assign valid_res     = vres_reg;
    assign fresh         = fresh_reg;

    always_comb
    begin
        header_next = cfg_we ? cfg_wdata : header_reg;
        op_next     = op_reg;
        byte_next   = byte_reg;
        phase_next  = phase_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        slot_next   = slot_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        dq_next     = dq_reg;
        dcnt_next   = dcnt_reg;
        mean_next   = mean_reg;
        vres_next   = vres_reg;
        fresh_next  = fresh_reg;
        ovalid_next = ovalid_reg && out_stall;

        unique case (uop)
            U_WAIT:
            begin
                if (in_take)
                begin
                    op_next   = operation;
                    byte_next = rx_byte;
                end
            end
            U_PARSE:
            begin
                if (op_reg)
                begin
                    phase_next = PH_HUNT;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_HUNT:
                        begin
                            if (byte_reg == header_reg)
                            begin
                                phase_next = PH_HIGH;
                            end
                        end
                        PH_HIGH:
                        begin
                            hi_next    = byte_reg;
                            phase_next = PH_LOW;
                        end
                        PH_LOW:
                        begin
                            lo_next    = byte_reg;
                            phase_next = PH_CSUM;
                        end
                        default:
                        begin
                            phase_next = PH_HUNT;
                            if (frame_ok)
                            begin
                                slot_next = (slot_reg == SLOT_W'(DEPTH - 1)) ? '0
                                          : SLOT_W'(slot_reg + 1'b1);
                                if (count_reg != CNT_W'(DEPTH))
                                begin
                                    count_next = CNT_W'(count_reg + 1'b1);
                                end
                            end
                        end
                    endcase
                end
            end
            U_CLR:
            begin
                acc_next = '0;
                idx_next = '0;
            end
            U_ACC:
            begin
                if (idx_reg < count_reg)
                begin
                    acc_next = acc_reg + SUM_W'(ring[idx_reg[SLOT_W-1:0]]);
                    idx_next = idx_inc[CNT_W-1:0];
                end
            end
            U_DIVINIT:
            begin
                rem_next  = acc_reg[SUM_W-1:MEAN_W];
                dq_next   = acc_reg[MEAN_W-1:0];
                dcnt_next = DIV_CNT_W'(DIV_STEPS - 1);
            end
            U_DIV:
            begin
                rem_next  = ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
                dq_next   = {dq_reg[MEAN_W-2:0], ge};
                dcnt_next = DIV_CNT_W'(dcnt_reg - 1'b1);
            end
            U_EMIT:
            begin
                if (!out_busy)
                begin
                    ovalid_next = 1'b1;
                    vres_next   = (count_reg != '0);
                    mean_next   = (count_reg != '0) ? dq_reg : '0;
                    fresh_next  = !op_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HDR_RESET;
            phase_reg  <= PH_HUNT;
            hi_reg     <= '0;
            lo_reg     <= '0;
            slot_reg   <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            dcnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            header_reg <= header_next;
            phase_reg  <= phase_next;
            hi_reg     <= hi_next;
            lo_reg     <= lo_next;
            slot_reg   <= slot_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            dcnt_reg   <= dcnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        byte_reg  <= byte_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        dq_reg    <= dq_next;
        mean_reg  <= mean_next;
        vres_reg  <= vres_next;
        fresh_reg <= fresh_next;
        if (ring_we)
        begin
            ring[slot_reg] <= {hi_reg, lo_reg};
        end
    end

endmodule

>>> sv/distance_frame_parser_averager_core.sv
// Distance frame parser averager top level: microcode sequencer driving the datapath.
// A result goes through the parse, clear, accumulate, divide-init, divide and emit steps;
// emit waits while out_stall holds the output. An item without a result passes only wait
// and parse. in_stall holds new items off until the sequencer is back in its wait step.
// The serial 16-step divider and the one-entry-per-cycle ring sum set an item's pace.
// Reset clears the parser, ring count, write slot and output valid; header resets to 0xFF.
module distance_frame_parser_averager_core
    import dfpa_pkg::*;
#(
    parameter int DEPTH = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [BYTE_W-1:0] cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              operation,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [MEAN_W-1:0] mean_distance,
    output logic              valid_res,
    output logic              fresh
);

    uop_t       uop;
    dp_status_t status;

    dfpa_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .uop    (uop)
    );

    dfpa_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .uop           (uop),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mean_distance (mean_distance),
        .valid_res     (valid_res),
        .fresh         (fresh)
    );

endmodule

>>> verif/tb.sv
// Testbench for the distance frame parser averager: scoreboard-checked frames, noise and timeouts.
module tb
    import dfpa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RING_DEPTH    = 5;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          QUIET_LIMIT   = 3000;
    localparam int          SHOW_LIMIT    = 10;
    localparam logic        OP_BYTE       = 1'b0;
    localparam logic        OP_TIMEOUT    = 1'b1;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic              ok;
        logic              fresh;
    } mean_result_t;

    class frame_mean_scoreboard;
        logic [BYTE_W-1:0] header;
        phase_t            phase;
        logic [BYTE_W-1:0] high_b;
        logic [BYTE_W-1:0] low_b;
        logic [MEAN_W-1:0] readings [RING_DEPTH];
        int unsigned       next_slot;
        int unsigned       held;
        mean_result_t      expected_means [$];
        int unsigned       fail_count;

        function new();
            header     = HDR_RESET;
            phase      = PH_HUNT;
            high_b     = '0;
            low_b      = '0;
            next_slot  = 0;
            held       = 0;
            fail_count = 0;
            foreach (readings[i])
                readings[i] = '0;
        endfunction

        function void push_mean(logic is_fresh);
            mean_result_t r;
            int unsigned  total;
            int unsigned  k;
            total = 0;
            for (k = 0; k < held; k++)
                total += readings[k];
            r.fresh = is_fresh;
            if (held == 0)
            begin
                r.mean = '0;
                r.ok   = 1'b0;
            end
            else
            begin
                r.mean = MEAN_W'(total / held);
                r.ok   = 1'b1;
            end
            expected_means.push_back(r);
        endfunction

        function void note_word(logic op, logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] sum;
            if (op == OP_TIMEOUT)
            begin
                phase = PH_HUNT;
                push_mean(1'b0);
                return;
            end
            unique case (phase)
                PH_HUNT:
                begin
                    if (b == header)
                        phase = PH_HIGH;
                end
                PH_HIGH:
                begin
                    high_b = b;
                    phase  = PH_LOW;
                end
                PH_LOW:
                begin
                    low_b = b;
                    phase = PH_CSUM;
                end
                default:
                begin
                    sum   = header + high_b + low_b;
                    phase = PH_HUNT;
                    if (sum == b)
                    begin
                        readings[next_slot] = {high_b, low_b};
                        next_slot = (next_slot + 1) % RING_DEPTH;
                        if (held < RING_DEPTH)
                            held++;
                        push_mean(1'b1);
                    end
                end
            endcase
        endfunction

        function void check_result(mean_result_t got);
            mean_result_t want;
            if (expected_means.size() == 0)
            begin
                fail_count++;
                if (fail_count <= SHOW_LIMIT)
                    $display("%0t: unexpected result mean=%h valid_res=%b fresh=%b",
                             $realtime, got.mean, got.ok, got.fresh);
                return;
            end
            want = expected_means.pop_front();
            if (got.mean !== want.mean || got.ok !== want.ok || got.fresh !== want.fresh)
            begin
                fail_count++;
                if (fail_count <= SHOW_LIMIT)
                    $display("%0t: exp mean=%h ok=%b fresh=%b, got mean=%h ok=%b fresh=%b",
                             $realtime, want.mean, want.ok, want.fresh,
                             got.mean, got.ok, got.fresh);
            end
        endfunction
    endclass

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              cfg_we        = 1'b0;
    logic [BYTE_W-1:0] cfg_wdata     = '0;
    logic              in_valid      = 1'b0;
    logic              in_stall;
    logic              operation     = OP_BYTE;
    logic [BYTE_W-1:0] rx_byte       = '0;
    logic              out_valid;
    logic              out_stall     = 1'b0;
    logic [MEAN_W-1:0] mean_distance;
    logic              valid_res;
    logic              fresh;

    logic              calm          = 1'b0;
    int unsigned       quiet_cycles  = 0;
    frame_mean_scoreboard sb;

    distance_frame_parser_averager_core #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mean_distance(mean_distance),
        .valid_res    (valid_res),
        .fresh        (fresh)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 22);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_word(operation, rx_byte);
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{mean: mean_distance, ok: valid_res, fresh: fresh});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [BYTE_W-1:0] pick_byte();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return BYTE_W'($urandom_range(255));
    endfunction

    task automatic send_word(logic op, logic [BYTE_W-1:0] b);
        while (!calm && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        rx_byte   <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_frame(logic [BYTE_W-1:0] hi, logic [BYTE_W-1:0] lo,
                              logic [BYTE_W-1:0] csum);
        send_word(OP_BYTE, sb.header);
        send_word(OP_BYTE, hi);
        send_word(OP_BYTE, lo);
        send_word(OP_BYTE, csum);
    endtask

    task automatic send_good_frame(logic [BYTE_W-1:0] hi, logic [BYTE_W-1:0] lo);
        logic [BYTE_W-1:0] csum;
        csum = sb.header + hi + lo;
        send_frame(hi, lo, csum);
    endtask

    task automatic send_cut_frame();
        int unsigned k;
        int unsigned n;
        n = $urandom_range(2);
        send_word(OP_BYTE, sb.header);
        for (k = 0; k < n; k++)
            send_word(OP_BYTE, pick_byte());
        send_word(OP_TIMEOUT, pick_byte());
    endtask

    task automatic random_traffic(int unsigned n_words);
        int unsigned       sent;
        int unsigned       r;
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
        sent = 0;
        while (sent < n_words)
        begin
            r  = $urandom_range(99);
            hi = pick_byte();
            lo = pick_byte();
            if (r < 58)
            begin
                send_good_frame(hi, lo);
                sent += 4;
            end
            else if (r < 70)
            begin
                send_frame(hi, lo, (sb.header + hi + lo) ^ BYTE_W'($urandom_range(1, 255)));
                sent += 4;
            end
            else if (r < 80)
            begin
                send_cut_frame();
                sent += 3;
            end
            else if (r < 90)
            begin
                send_word(OP_BYTE, pick_byte());
                sent += 1;
            end
            else
            begin
                send_word(OP_TIMEOUT, pick_byte());
                sent += 1;
            end
        end
        in_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (sb.expected_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_header(logic [BYTE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.header = value;
    endtask

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(OP_TIMEOUT, 8'h00);
        send_word(OP_BYTE, 8'h12);
        send_good_frame(8'h00, 8'h00);
        send_good_frame(8'hFF, 8'hFF);
        send_frame(8'h12, 8'h34, 8'h00);
        send_word(OP_BYTE, sb.header);
        send_word(OP_TIMEOUT, 8'hFF);
        send_good_frame(8'h80, 8'h01);
        send_word(OP_TIMEOUT, 8'h5A);
        in_valid <= 1'b0;
        drain_results();

        random_traffic(250);
        drain_results();

        write_header(8'h00);
        calm <= 1'b1;
        random_traffic(250);
        drain_results();
        calm <= 1'b0;

        write_header(8'hFF);
        random_traffic(200);
        drain_results();

        write_header(BYTE_W'($urandom_range(1, 254)));
        random_traffic(200);
        drain_results();

        write_header(BYTE_W'($urandom_range(255)));
        random_traffic(200);
        drain_results();

        if (sb.fail_count == 0 && sb.expected_means.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
